[rtl/ptsd_pkg.sv]
`timescale 1ns / 1ps

package ptsd_pkg;

  // Result word and divider depth
  localparam int OUT_BITS    = 34;
  localparam int OUT_TDATA_W = 40;
  localparam int DIV_Q       = OUT_BITS;

  // Latency of one pipelined multiplier
  localparam int MUL_LAT = 2;

  // Candidate chosen by the region split
  typedef enum logic [3:0] {
    SEL_VA,   // vertex a
    SEL_VB,   // vertex b
    SEL_VC,   // vertex c
    SEL_E0,   // edge ab
    SEL_E1,   // edge ac
    SEL_E2,   // edge bc, measured from c
    SEL_E3,   // edge bc, measured from b
    SEL_INT   // face interior
  } sel_t;

endpackage

[rtl/ptsd_pipe.sv]
`timescale 1ns / 1ps

// Plain delay line for payload that waits beside a multiplier
module ptsd_pipe #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

[rtl/ptsd_mul.sv]
`timescale 1ns / 1ps

// Signed multiplier, two stages: four partial products, then the sum
module ptsd_mul #(
  parameter int WA = 17,
  parameter int WB = 17
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int WL = WB / 4;
  localparam int WH = WB - 3 * WL;
  localparam int WO = WA + WB;

  logic signed [WA+WL:0]   pq_r [3];
  logic signed [WA+WH-1:0] hi_r;
  logic signed [WO-1:0]    p_r;
  logic signed [WO-1:0]    pq_x [3];
  logic signed [WO-1:0]    hi_x;

  // low quarters are taken as unsigned, top part carries the sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pq_r[k] <= a * $signed({1'b0, b[k*WL +: WL]});
      end
      hi_r <= a * $signed(b[WB-1:3*WL]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pq_x[k] = WO'(pq_r[k]);
    end
  end

  assign hi_x = WO'(hi_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (hi_x <<< (3*WL)) + (pq_x[2] <<< (2*WL)) + (pq_x[1] <<< WL) + pq_x[0];
    end
  end

  assign p = p_r;

endmodule

[rtl/ptsd_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, floor of num / den.
// Negative numerator or non-positive denominator gives zero; a quotient
// that does not fit the result word saturates.
module ptsd_div #(
  parameter int WN = 64,
  parameter int WD = 48
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [WN-1:0]              num,
  input  logic signed [WD-1:0]              den,
  output logic        [ptsd_pkg::OUT_BITS-1:0] quo
);

  import ptsd_pkg::*;

  localparam int Q = DIV_Q;

  logic signed [WN-1:0] hi;
  logic                 clr0;
  logic                 sat0;

  logic [WD-1:0] rem_r [Q+1];
  logic [WD-1:0] den_r [Q+1];
  logic [Q-1:0]  nlo_r [Q+1];
  logic [Q-1:0]  q_r   [Q+1];
  logic          sat_r [Q+1];
  logic          clr_r [Q+1];

  // Entry: range checks and upper numerator bits as first remainder
  assign hi   = num >>> Q;
  assign clr0 = num[WN-1] | den[WD-1] | (den == '0);
  assign sat0 = !clr0 && (hi >= WN'(den));

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi[WD-1:0];
      den_r[0] <= den;
      nlo_r[0] <= num[Q-1:0];
      q_r[0]   <= '0;
      sat_r[0] <= sat0;
      clr_r[0] <= clr0;
    end
  end

  // One compare and subtract per stage
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [WD:0]   r2;
    logic          ge;
    logic [Q-1:0]  q_nxt;
    logic [WD-1:0] rem_nxt;

    always_comb begin
      r2      = {rem_r[k], nlo_r[k][Q-1-k]};
      ge      = (r2 >= {1'b0, den_r[k]});
      rem_nxt = ge ? WD'(r2 - {1'b0, den_r[k]}) : r2[WD-1:0];
      q_nxt   = q_r[k];
      q_nxt[Q-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        den_r[k+1] <= den_r[k];
        nlo_r[k+1] <= nlo_r[k];
        q_r[k+1]   <= q_nxt;
        sat_r[k+1] <= sat_r[k];
        clr_r[k+1] <= clr_r[k];
      end
    end
  end

  assign quo = clr_r[Q] ? '0 : (sat_r[Q] ? '1 : q_r[Q]);

endmodule

[rtl/point_triangle_sqr_distance.sv]
`timescale 1ns / 1ps

// Squared distance from a query point to a 3D triangle, exact integer
// arithmetic, floored to whole squared units and saturated to 34 bits.
// Fully pipelined: one item per clock while the output is not stalled;
// the differences, dot products and three multiplier rounds are followed
// by the bit-per-stage divider that forms the 34 quotient bits. A stall
// on the output holds the whole pipeline; no reset pass is needed.
module point_triangle_sqr_distance #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
  // vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z (COORD_BITS each)
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]      in_tdata,

  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // sqr_distance [33:0], zero padding above
  output logic [ptsd_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  import ptsd_pkg::*;

  localparam int N   = COORD_BITS;
  localparam int WE  = N + 1;
  localparam int WPR = 2 * WE;
  localparam int WS  = 2 * N + 6;
  localparam int WP  = 2 * WS;
  localparam int WT  = WP + 2;
  localparam int WM3 = WS + WT;
  localparam int WN  = WM3 + 2;
  localparam int NSC = 11;
  localparam int LAT = 1 + MUL_LAT + 1 + MUL_LAT + 1 + MUL_LAT + 1 + 1 + DIV_Q;

  logic en;
  logic [LAT-1:0] v_r;

  // Pipeline advances unless the output holds an untaken result
  assign en        = !v_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  // Input register; the differences below sign-extend coordinates by one bit
  logic signed [N-1:0] x_r [12];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        x_r[k] <= in_tdata[k*N +: N];
      end
    end
  end

  // d = a - p, e0 = b - a, e1 = c - a
  logic signed [WE-1:0] d  [3];
  logic signed [WE-1:0] e0 [3];
  logic signed [WE-1:0] e1 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k]  = WE'(x_r[k])     - WE'(x_r[9+k]);
      e0[k] = WE'(x_r[3+k])   - WE'(x_r[k]);
      e1[k] = WE'(x_r[6+k])   - WE'(x_r[k]);
    end
  end

  // First multiplier round: component products of the six dot products
  logic signed [WE-1:0]  m1a [18];
  logic signed [WE-1:0]  m1b [18];
  logic signed [WPR-1:0] m1p [18];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m1a[k]    = e0[k]; m1b[k]    = e0[k];
      m1a[3+k]  = e0[k]; m1b[3+k]  = e1[k];
      m1a[6+k]  = e1[k]; m1b[6+k]  = e1[k];
      m1a[9+k]  = d[k];  m1b[9+k]  = e0[k];
      m1a[12+k] = d[k];  m1b[12+k] = e1[k];
      m1a[15+k] = d[k];  m1b[15+k] = d[k];
    end
  end

  for (genvar g = 0; g < 18; g++) begin : g_mul1
    ptsd_mul #(.WA(WE), .WB(WE)) u_mul (
      .clk (clk), .en (en), .a (m1a[g]), .b (m1b[g]), .p (m1p[g])
    );
  end

  // Dot products: a00, a01, a11, b0, b1, c
  logic signed [WS-1:0] sc_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        sc_r[j] <= WS'(m1p[3*j]) + WS'(m1p[3*j+1]) + WS'(m1p[3*j+2]);
      end
    end
  end

  // Derived scalars for the vertex and edge candidates
  logic signed [WS-1:0] s_vb, s_vc, s_dn, s_n2, s_n3;

  always_comb begin
    s_vb = sc_r[0] + (sc_r[3] <<< 1) + sc_r[5];
    s_vc = sc_r[2] + (sc_r[4] <<< 1) + sc_r[5];
    s_dn = sc_r[0] - (sc_r[1] <<< 1) + sc_r[2];
    s_n2 = sc_r[0] + sc_r[3] - sc_r[1] - sc_r[4];
    s_n3 = sc_r[2] + sc_r[4] - sc_r[1] - sc_r[3];
  end

  // Second multiplier round: determinant, S and T terms and edge numerators
  logic signed [WS-1:0] m2a [14];
  logic signed [WS-1:0] m2b [14];
  logic signed [WP-1:0] m2p [14];

  always_comb begin
    m2a[0]  = sc_r[0]; m2b[0]  = sc_r[2];
    m2a[1]  = sc_r[1]; m2b[1]  = sc_r[1];
    m2a[2]  = sc_r[1]; m2b[2]  = sc_r[4];
    m2a[3]  = sc_r[2]; m2b[3]  = sc_r[3];
    m2a[4]  = sc_r[1]; m2b[4]  = sc_r[3];
    m2a[5]  = sc_r[0]; m2b[5]  = sc_r[4];
    m2a[6]  = sc_r[5]; m2b[6]  = sc_r[0];
    m2a[7]  = sc_r[3]; m2b[7]  = sc_r[3];
    m2a[8]  = sc_r[5]; m2b[8]  = sc_r[2];
    m2a[9]  = sc_r[4]; m2b[9]  = sc_r[4];
    m2a[10] = s_vc;    m2b[10] = s_dn;
    m2a[11] = s_n3;    m2b[11] = s_n3;
    m2a[12] = s_vb;    m2b[12] = s_dn;
    m2a[13] = s_n2;    m2b[13] = s_n2;
  end

  for (genvar g = 0; g < 14; g++) begin : g_mul2
    ptsd_mul #(.WA(WS), .WB(WS)) u_mul (
      .clk (clk), .en (en), .a (m2a[g]), .b (m2b[g]), .p (m2p[g])
    );
  end

  // Scalars wait beside the second round and the next register
  logic [NSC*WS-1:0] sc_pk, sc_dl;
  logic signed [WS-1:0] q_a00, q_a01, q_a11, q_b0, q_b1, q_c;
  logic signed [WS-1:0] q_vb, q_vc, q_dn, q_n2, q_n3;

  assign sc_pk = {s_n3, s_n2, s_dn, s_vc, s_vb,
                  sc_r[5], sc_r[4], sc_r[3], sc_r[2], sc_r[1], sc_r[0]};

  ptsd_pipe #(.W(NSC*WS), .DEPTH(MUL_LAT + 1)) u_sc_dly (
    .clk (clk), .en (en), .din (sc_pk), .dout (sc_dl)
  );

  assign {q_n3, q_n2, q_dn, q_vc, q_vb, q_c, q_b1, q_b0, q_a11, q_a01, q_a00} = sc_dl;

  // D, S, T and edge numerators
  logic signed [WT-1:0] det_r, s_r, t_r;
  logic signed [WT-1:0] en_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= WT'(m2p[0]) - WT'(m2p[1]);
      s_r   <= WT'(m2p[2]) - WT'(m2p[3]);
      t_r   <= WT'(m2p[4]) - WT'(m2p[5]);
      for (int k = 0; k < 4; k++) begin
        en_r[k] <= WT'(m2p[6+2*k]) - WT'(m2p[7+2*k]);
      end
    end
  end

  // Region split
  logic signed [WT:0] st_sum;
  logic               s_neg, t_neg, b0_neg, b1_neg;
  logic               b0_far, b1_far;
  sel_t               sel;

  always_comb begin
    st_sum = (WT+1)'(s_r) + (WT+1)'(t_r);
    s_neg  = s_r[WT-1];
    t_neg  = t_r[WT-1];
    b0_neg = q_b0[WS-1];
    b1_neg = q_b1[WS-1];
    b0_far = (q_a00 + q_b0) <= 0;
    b1_far = (q_a11 + q_b1) <= 0;
    sel    = SEL_VA;
    if (st_sum <= (WT+1)'(det_r)) begin
      if (s_neg && t_neg && b0_neg) begin
        sel = b0_far ? SEL_VB : SEL_E0;
      end else if (s_neg) begin
        if (!b1_neg)     sel = SEL_VA;
        else if (b1_far) sel = SEL_VC;
        else             sel = SEL_E1;
      end else if (t_neg) begin
        if (!b0_neg)     sel = SEL_VA;
        else if (b0_far) sel = SEL_VB;
        else             sel = SEL_E0;
      end else if (det_r == '0) begin
        sel = SEL_VA;
      end else begin
        sel = SEL_INT;
      end
    end else if (s_neg) begin
      if ((q_a11 + q_b1) > (q_a01 + q_b0)) begin
        sel = (q_n3 >= q_dn) ? SEL_VB : SEL_E2;
      end else if ((q_a11 + q_b1) <= 0) begin
        sel = SEL_VC;
      end else if (!b1_neg) begin
        sel = SEL_VA;
      end else begin
        sel = SEL_E1;
      end
    end else if (t_neg) begin
      if ((q_a00 + q_b0) > (q_a01 + q_b1)) begin
        sel = (q_n2 >= q_dn) ? SEL_VC : SEL_E3;
      end else if ((q_a00 + q_b0) <= 0) begin
        sel = SEL_VB;
      end else if (!b0_neg) begin
        sel = SEL_VA;
      end else begin
        sel = SEL_E0;
      end
    end else begin
      if (q_n3 <= 0)          sel = SEL_VC;
      else if (q_n3 >= q_dn)  sel = SEL_VB;
      else                    sel = SEL_E2;
    end
  end

  // Candidate fraction for every region but the interior
  localparam logic signed [WT-1:0] ONE_T = WT'(1);

  logic signed [WT-1:0] c_num, c_den;
  logic                 is_int;

  always_comb begin
    is_int = 1'b0;
    c_num  = WT'(q_c);
    c_den  = ONE_T;
    unique case (sel)
      SEL_VA:  begin c_num = WT'(q_c);  c_den = ONE_T;       end
      SEL_VB:  begin c_num = WT'(q_vb); c_den = ONE_T;       end
      SEL_VC:  begin c_num = WT'(q_vc); c_den = ONE_T;       end
      SEL_E0:  begin c_num = en_r[0];   c_den = WT'(q_a00);  end
      SEL_E1:  begin c_num = en_r[1];   c_den = WT'(q_a11);  end
      SEL_E2:  begin c_num = en_r[2];   c_den = WT'(q_dn);   end
      SEL_E3:  begin c_num = en_r[3];   c_den = WT'(q_dn);   end
      SEL_INT: begin is_int = 1'b1;     c_den = det_r;       end
      default: begin c_num = WT'(q_c);  c_den = ONE_T;       end
    endcase
  end

  // Third multiplier round: interior numerator c*D + B0*S + B1*T
  logic signed [WS-1:0]  m3a [3];
  logic signed [WT-1:0]  m3b [3];
  logic signed [WM3-1:0] m3p [3];

  assign m3a[0] = q_c;  assign m3b[0] = det_r;
  assign m3a[1] = q_b0; assign m3b[1] = s_r;
  assign m3a[2] = q_b1; assign m3b[2] = t_r;

  for (genvar g = 0; g < 3; g++) begin : g_mul3
    ptsd_mul #(.WA(WS), .WB(WT)) u_mul (
      .clk (clk), .en (en), .a (m3a[g]), .b (m3b[g]), .p (m3p[g])
    );
  end

  logic [2*WT:0]        cd_pk, cd_dl;
  logic signed [WT-1:0] w_num, w_den;
  logic                 w_int;

  assign cd_pk = {is_int, c_num, c_den};

  ptsd_pipe #(.W(2*WT+1), .DEPTH(MUL_LAT)) u_cd_dly (
    .clk (clk), .en (en), .din (cd_pk), .dout (cd_dl)
  );

  assign {w_int, w_num, w_den} = cd_dl;

  // Final fraction into the divider
  logic signed [WN-1:0] num_r;
  logic signed [WT-1:0] den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= w_int ? (WN'(m3p[0]) + WN'(m3p[1]) + WN'(m3p[2])) : WN'(w_num);
      den_r <= w_den;
    end
  end

  logic [OUT_BITS-1:0] quo;

  ptsd_div #(.WN(WN), .WD(WT)) u_div (
    .clk (clk), .en (en), .num (num_r), .den (den_r), .quo (quo)
  );

  assign out_tvalid = v_r[LAT-1];
  assign out_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, quo};

  // Checks
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted item not entered in pipeline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(v_r))
    else $error("pipeline moved during stall");

endmodule

[bench/tb_point_triangle_sqr_distance.sv]
`timescale 1ns / 1ps

module tb_point_triangle_sqr_distance;
  import ptsd_pkg::*;

  localparam int CB      = 16;
  localparam int IN_W    = ((12*CB+7)/8)*8;
  localparam int LAT     = 45;
  localparam int WD_MAX  = 20000;
  localparam logic [33:0] DIST_MAX = 34'h3FFFFFFFF;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
  } tri_query_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  point_triangle_sqr_distance #(.COORD_BITS(CB)) dut (.*);

  always #2 clk = ~clk;

  tri_query_t  pending_q[$];
  logic [33:0] dist_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_send = 1'b0;
  int quiet_cycles = 0;

  // Floor of n / m, clamped at zero and saturated to the result width
  function automatic logic [33:0] div_sat(logic signed [191:0] n, logic signed [191:0] m);
    logic signed [191:0] q;
    if (n < 0 || m <= 0) return '0;
    q = n / m;
    if (q > DIST_MAX) return DIST_MAX;
    return q[33:0];
  endfunction

  // (base*m - x^2) / m: minimum along one edge
  function automatic logic [33:0] edge_dist(longint base, longint x, longint m);
    logic signed [191:0] wb, wx, wm;
    wb = base; wx = x; wm = m;
    return div_sat(wb*wm - wx*wx, wm);
  endfunction

  function automatic logic [33:0] tri_dist(tri_query_t it);
    longint a[3], b[3], c[3], p[3], d[3], e0[3], e1[3];
    longint a00, a01, a11, b0, b1, cc, va, vb, vc, den, t0, t1, num;
    logic signed [191:0] dd, ss, tt, w00, w01, w11, wb0, wb1, wc;
    logic [33:0] r;
    a = '{it.ax, it.ay, it.az}; b = '{it.bx, it.by, it.bz};
    c = '{it.cx, it.cy, it.cz}; p = '{it.px, it.py, it.pz};
    for (int k = 0; k < 3; k++) begin
      d[k] = a[k] - p[k]; e0[k] = b[k] - a[k]; e1[k] = c[k] - a[k];
    end
    a00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    a01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    a11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    b0  = d[0]*e0[0] + d[1]*e0[1] + d[2]*e0[2];
    b1  = d[0]*e1[0] + d[1]*e1[1] + d[2]*e1[2];
    cc  = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    va = cc; vb = a00 + 2*b0 + cc; vc = a11 + 2*b1 + cc;
    w00 = a00; w01 = a01; w11 = a11; wb0 = b0; wb1 = b1; wc = cc;
    dd = w00*w11 - w01*w01;
    ss = w01*wb1 - w11*wb0;
    tt = w01*wb0 - w00*wb1;
    if (ss + tt <= dd) begin
      if (ss < 0 && tt < 0 && b0 < 0)
        r = (-b0 >= a00) ? div_sat(vb, 1) : edge_dist(cc, b0, a00);
      else if (ss < 0) begin
        if (b1 >= 0) r = div_sat(va, 1);
        else if (-b1 >= a11) r = div_sat(vc, 1);
        else r = edge_dist(cc, b1, a11);
      end else if (tt < 0) begin
        if (b0 >= 0) r = div_sat(va, 1);
        else if (-b0 >= a00) r = div_sat(vb, 1);
        else r = edge_dist(cc, b0, a00);
      end else if (dd == 0) r = div_sat(wc, 1);
      else r = div_sat(wc*dd + wb0*ss + wb1*tt, dd);
    end else begin
      den = a00 - 2*a01 + a11;
      if (ss < 0) begin
        t0 = a01 + b0; t1 = a11 + b1;
        if (t1 > t0) begin
          num = t1 - t0;
          r = (num >= den) ? div_sat(vb, 1) : edge_dist(vc, num, den);
        end else if (t1 <= 0) r = div_sat(vc, 1);
        else if (b1 >= 0) r = div_sat(va, 1);
        else r = edge_dist(cc, b1, a11);
      end else if (tt < 0) begin
        t0 = a01 + b1; t1 = a00 + b0;
        if (t1 > t0) begin
          num = t1 - t0;
          r = (num >= den) ? div_sat(vc, 1) : edge_dist(vb, num, den);
        end else if (t1 <= 0) r = div_sat(vb, 1);
        else if (b0 >= 0) r = div_sat(va, 1);
        else r = edge_dist(cc, b0, a00);
      end else begin
        num = a11 + b1 - a01 - b0;
        if (num <= 0) r = div_sat(vc, 1);
        else if (num >= den) r = div_sat(vb, 1);
        else r = edge_dist(vc, num, den);
      end
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_query(tri_query_t it);
    return {it.pz, it.py, it.px, it.cz, it.cy, it.cx, it.bz, it.by, it.bx,
            it.az, it.ay, it.ax};
  endfunction

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2*span) - span);
  endfunction

  // Small triangle near a random centre, query nearby, or all coordinates fully random
  function automatic tri_query_t rnd_query();
    tri_query_t it;
    int span, base[3], sel;
    sel = $urandom_range(9);
    span = (sel < 3) ? 0 : (sel < 6) ? 200 : (sel < 8) ? 4000 : 20;
    for (int k = 0; k < 3; k++) base[k] = (span == 0) ? 0 : $urandom_range(20000) - 10000;
    it.ax = coord_t'(base[0] + rnd_coord(span)); it.ay = coord_t'(base[1] + rnd_coord(span));
    it.az = coord_t'(base[2] + rnd_coord(span));
    it.bx = coord_t'(base[0] + rnd_coord(span)); it.by = coord_t'(base[1] + rnd_coord(span));
    it.bz = coord_t'(base[2] + rnd_coord(span));
    if ($urandom_range(9) == 0) begin
      // collinear or repeated vertex
      it.cx = it.bx; it.cy = it.by; it.cz = it.bz;
    end else begin
      it.cx = coord_t'(base[0] + rnd_coord(span)); it.cy = coord_t'(base[1] + rnd_coord(span));
      it.cz = coord_t'(base[2] + rnd_coord(span));
    end
    it.px = coord_t'(base[0] + rnd_coord(span)); it.py = coord_t'(base[1] + rnd_coord(span));
    it.pz = coord_t'(base[2] + rnd_coord(span));
    return it;
  endfunction

  function automatic tri_query_t mk(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz, int px, int py, int pz);
    tri_query_t it;
    it.ax = coord_t'(ax); it.ay = coord_t'(ay); it.az = coord_t'(az);
    it.bx = coord_t'(bx); it.by = coord_t'(by); it.bz = coord_t'(bz);
    it.cx = coord_t'(cx); it.cy = coord_t'(cy); it.cz = coord_t'(cz);
    it.px = coord_t'(px); it.py = coord_t'(py); it.pz = coord_t'(pz);
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [33:0] got, logic [33:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        dist_q.push_back(tri_dist(pending_q.pop_front()));
      end
      if ((!in_tvalid || in_tready)) begin
        if (pending_q.size() != (in_tvalid && in_tready ? 0 : 0) && !hold_send
            && ($urandom_range(99) >= send_idle) && pending_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pack_query(pending_q[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (dist_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_tdata[33:0], '0);
        end else begin
          logic [33:0] want;
          want = dist_q.pop_front();
          if (out_tdata[33:0] !== want) report_mismatch("sqr_distance", out_tdata[33:0], want);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_MAX) begin
        $display("point_triangle_sqr_distance test failed");
        $finish;
      end
    end
  end

  task automatic drain_all();
    while (pending_q.size() > 0 || in_tvalid || dist_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int lim = 32767, neg = -32768;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each region, degenerate shapes
    pending_q.push_back(mk(0,0,0, 0,0,0, 0,0,0, 0,0,0));
    pending_q.push_back(mk(neg,neg,neg, neg,neg,neg, neg,neg,neg, lim,lim,lim));
    pending_q.push_back(mk(lim,lim,lim, lim,lim,lim, lim,lim,lim, neg,neg,neg));
    pending_q.push_back(mk(neg,neg,neg, lim,lim,lim, neg,lim,neg, lim,neg,lim));
    pending_q.push_back(mk(-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1));
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, 20,20,7));    // interior
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, 50,-30,3));   // edge ab
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, -30,50,3));   // edge ac
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, 70,70,5));    // edge bc
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, -9,-9,1));    // vertex a
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, 150,-20,2));  // vertex b
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, -20,150,2));  // vertex c
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, 140,10,0));
    pending_q.push_back(mk(0,0,0, 100,0,0, 0,100,0, 10,140,0));
    pending_q.push_back(mk(0,0,0, 10,10,10, 20,20,20, 3,17,-4));  // collinear
    pending_q.push_back(mk(5,5,5, 5,5,5, 9,1,0, 7,3,8));          // repeated vertex
    pending_q.push_back(mk(1,2,3, 1,2,3, 1,2,3, 1,2,4));          // point-like
    pending_q.push_back(mk(lim,0,0, neg,0,0, 0,lim,0, 0,neg,lim));
    pending_q.push_back(mk(0,0,0, 3,0,0, 0,7,0, 1,1,-1));         // interior
    pending_q.push_back(mk(-5,lim,3, 8,neg,2, 0,0,lim, 0,0,neg));
    send_idle = 25; recv_idle = 64;
    drain_all();

    // Sender holds off mid-batch until everything is back
    for (int i = 0; i < 150; i++) pending_q.push_back(rnd_query());
    while (pending_q.size() > 75) @(posedge clk);
    hold_send = 1'b1;
    while (in_tvalid || dist_q.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    drain_all();
    send_idle = 64; recv_idle = 25;
    for (int i = 0; i < 150; i++) pending_q.push_back(rnd_query());
    drain_all();
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 150; i++) pending_q.push_back(rnd_query());
    drain_all();
    repeat (LAT + 10) @(posedge clk);

    if (errors == 0) $display("point_triangle_sqr_distance test passed");
    else $display("point_triangle_sqr_distance test failed");
    $finish;
  end

endmodule
